### rtl/ptv_pkg.sv
// Shared constants, types and bitplane helpers for the planar tile video memory port.
package ptv_pkg;

  localparam int unsigned TILE_AREA_BYTES = 6144;
  localparam int unsigned MAP_AREA_BYTES  = 2048;
  localparam int unsigned BANKS           = 2;

  localparam int unsigned ROWS_PER_BANK = (TILE_AREA_BYTES + 1) / 2;
  localparam int unsigned PIX_ROWS      = BANKS * ROWS_PER_BANK;
  localparam int unsigned MAP_DEPTH     = BANKS * MAP_AREA_BYTES;

  localparam int unsigned ROW_AW = (PIX_ROWS > 1) ? $clog2(PIX_ROWS) : 1;
  localparam int unsigned MAP_AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

  localparam int unsigned ADDR_W = 13;
  localparam int unsigned ROW_W  = 16;

  localparam logic [7:0] BYTE_BLOCKED = 8'hFF;
  localparam logic [1:0] MODE_BLOCK   = 2'd3;
  localparam logic       ACT_WRITE    = 1'b1;
  localparam logic [1:0] PX_HI        = 2'b10;
  localparam logic [1:0] PX_LO        = 2'b01;

  typedef logic [ROW_AW-1:0] prow_t;
  typedef logic [MAP_AW-1:0] midx_t;
  typedef logic [ROW_W-1:0]  row_t;

  // pixel i (0 = leftmost) sits in row[2i+1:2i]; byte bit 7-i maps to pixel i
  function automatic logic [7:0] plane_get(input row_t row, input logic hi);
    logic [7:0] b;
    logic [1:0] px;
    b = '0;
    for (int i = 0; i < 8; i++) begin
      px = row[2*i +: 2];
      b[7-i] = hi ? |(px & PX_HI) : |(px & PX_LO);
    end
    return b;
  endfunction

  function automatic row_t plane_put(input row_t row, input logic hi, input logic [7:0] val);
    row_t r;
    r = row;
    for (int i = 0; i < 8; i++) begin
      if (hi) r[2*i+1] = val[7-i];
      else    r[2*i]   = val[7-i];
    end
    return r;
  endfunction

endpackage

### rtl/ptv_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module ptv_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 8,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/planar_tile_vram_port.sv
// Top level of the planar tile video memory port.
// Banked video memory: tile data is held as rows of eight 2-bit pixels (one 16-bit word per
// row) and seen on the bus as bitplane bytes (even address = high plane, odd = low plane,
// bit 7 = leftmost pixel); addresses above the tile area reach a byte tile map. One request
// is accepted per cycle: the row or map byte is read in the accept cycle and the merged row
// is written back when the request leaves the stage, with forwarding when consecutive
// requests touch the same entry and the first is a write. Each request yields one response,
// held in the stage register and then the output register that drives out_tvalid; a held
// off output stalls the stage and then in_tready. After reset the pixel memory is cleared
// one row per cycle, and in_tready stays low during that pass. Mode 3 requests return 0xFF
// with accepted low and change nothing.
module planar_tile_vram_port (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [0] action, [13:1] address, [14] bank, [22:15] write_data, [24:23] display_mode
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] read_data, [8] accepted
  output logic [15:0] out_tdata
);

  typedef enum logic [1:0] {
    KIND_TILE,
    KIND_MAP,
    KIND_NONE,
    KIND_BLOCK
  } kind_t;

  logic                         in_act;
  logic [ptv_pkg::ADDR_W-1:0]   in_addr;
  logic                         in_bank;
  logic [7:0]                   in_wdata;
  logic [1:0]                   in_mode;
  logic                         bank_eff;
  logic [ptv_pkg::ADDR_W-1:0]   map_off;
  kind_t                        d_kind;
  ptv_pkg::prow_t               d_row;
  ptv_pkg::midx_t               d_midx;
  logic                         d_fwd;

  logic                         in_fire;
  logic                         s1_go;
  logic                         s1_fire;

  logic                         clr_busy_r;
  ptv_pkg::prow_t               clr_cnt_r;

  logic                         s1_v_r;
  logic                         s1_act_r;
  kind_t                        s1_kind_r;
  logic                         s1_hi_r;
  ptv_pkg::prow_t               s1_row_r;
  ptv_pkg::midx_t               s1_midx_r;
  logic [7:0]                   s1_wdata_r;
  logic                         s1_fwd_r;
  ptv_pkg::row_t                fwd_row_r;
  logic [7:0]                   fwd_map_r;

  ptv_pkg::row_t                pix_q;
  logic [7:0]                   map_q;
  ptv_pkg::row_t                cur_row;
  logic [7:0]                   cur_map;
  ptv_pkg::row_t                new_row;

  logic                         pix_we;
  ptv_pkg::prow_t               pix_waddr;
  ptv_pkg::row_t                pix_wdata;
  logic                         map_we;

  logic [7:0]                   rdata_nxt;
  logic                         acc_nxt;
  logic                         out_v_r;
  logic [7:0]                   out_rdata_r;
  logic                         out_acc_r;

  assign in_act   = in_tdata[0];
  assign in_addr  = in_tdata[13:1];
  assign in_bank  = in_tdata[14];
  assign in_wdata = in_tdata[22:15];
  assign in_mode  = in_tdata[24:23];

  assign bank_eff = (ptv_pkg::BANKS > 1) ? in_bank : 1'b0;
  assign map_off  = in_addr - ptv_pkg::ADDR_W'(ptv_pkg::TILE_AREA_BYTES);

  always_comb begin
    if (in_mode == ptv_pkg::MODE_BLOCK) begin
      d_kind = KIND_BLOCK;
    end else if (in_addr < ptv_pkg::ADDR_W'(ptv_pkg::TILE_AREA_BYTES)) begin
      d_kind = KIND_TILE;
    end else if (map_off < ptv_pkg::ADDR_W'(ptv_pkg::MAP_AREA_BYTES)) begin
      d_kind = KIND_MAP;
    end else begin
      d_kind = KIND_NONE;
    end
    d_row  = (d_kind == KIND_TILE)
           ? ptv_pkg::ROW_AW'(in_addr >> 1)
             + (bank_eff ? ptv_pkg::ROW_AW'(ptv_pkg::ROWS_PER_BANK) : '0)
           : '0;
    d_midx = ptv_pkg::MAP_AW'(map_off)
           + (bank_eff ? ptv_pkg::MAP_AW'(ptv_pkg::MAP_AREA_BYTES) : '0);
    d_fwd  = s1_v_r && (s1_act_r == ptv_pkg::ACT_WRITE)
           && (((s1_kind_r == KIND_TILE) && (d_kind == KIND_TILE) && (s1_row_r == d_row))
            || ((s1_kind_r == KIND_MAP) && (d_kind == KIND_MAP) && (s1_midx_r == d_midx)));
  end

  assign s1_go     = !out_v_r || out_tready;
  assign s1_fire   = s1_v_r && s1_go;
  assign in_tready = !clr_busy_r && (!s1_v_r || s1_go);
  assign in_fire   = in_tvalid && in_tready;

  assign cur_row = s1_fwd_r ? fwd_row_r : pix_q;
  assign cur_map = s1_fwd_r ? fwd_map_r : map_q;
  assign new_row = ptv_pkg::plane_put(cur_row, s1_hi_r, s1_wdata_r);

  always_comb begin
    if (clr_busy_r) begin
      pix_we    = 1'b1;
      pix_waddr = clr_cnt_r;
      pix_wdata = '0;
    end else begin
      pix_we    = s1_fire && (s1_act_r == ptv_pkg::ACT_WRITE) && (s1_kind_r == KIND_TILE);
      pix_waddr = s1_row_r;
      pix_wdata = new_row;
    end
  end

  assign map_we = s1_fire && (s1_act_r == ptv_pkg::ACT_WRITE) && (s1_kind_r == KIND_MAP);

  always_comb begin
    rdata_nxt = '0;
    acc_nxt   = 1'b1;
    unique case (s1_kind_r)
      KIND_BLOCK: begin
        rdata_nxt = ptv_pkg::BYTE_BLOCKED;
        acc_nxt   = 1'b0;
      end
      KIND_TILE: begin
        if (s1_act_r != ptv_pkg::ACT_WRITE) rdata_nxt = ptv_pkg::plane_get(cur_row, s1_hi_r);
      end
      KIND_MAP: begin
        if (s1_act_r != ptv_pkg::ACT_WRITE) rdata_nxt = cur_map;
      end
      default: begin
        rdata_nxt = '0;
      end
    endcase
  end

  ptv_ram #(
    .DEPTH (ptv_pkg::PIX_ROWS),
    .WIDTH (ptv_pkg::ROW_W),
    .AW    (ptv_pkg::ROW_AW)
  ) u_pix_ram (
    .clk   (clk),
    .we    (pix_we),
    .waddr (pix_waddr),
    .wdata (pix_wdata),
    .re    (in_fire),
    .raddr (d_row),
    .rdata (pix_q)
  );

  ptv_ram #(
    .DEPTH (ptv_pkg::MAP_DEPTH),
    .WIDTH (8),
    .AW    (ptv_pkg::MAP_AW)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (s1_midx_r),
    .wdata (s1_wdata_r),
    .re    (in_fire),
    .raddr (d_midx),
    .rdata (map_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
      s1_v_r     <= 1'b0;
      s1_fwd_r   <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == ptv_pkg::ROW_AW'(ptv_pkg::PIX_ROWS - 1)) clr_busy_r <= 1'b0;
      end
      if (in_fire) begin
        s1_v_r   <= 1'b1;
        s1_fwd_r <= d_fwd;
      end else if (s1_fire) begin
        s1_v_r   <= 1'b0;
        s1_fwd_r <= 1'b0;
      end
      if (s1_fire) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_act_r   <= in_act;
      s1_kind_r  <= d_kind;
      s1_hi_r    <= ~in_addr[0];
      s1_row_r   <= d_row;
      s1_midx_r  <= d_midx;
      s1_wdata_r <= in_wdata;
    end
    if (s1_fire) begin
      fwd_row_r   <= new_row;
      fwd_map_r   <= s1_wdata_r;
      out_rdata_r <= rdata_nxt;
      out_acc_r   <= acc_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0, out_acc_r, out_rdata_r};

`ifndef SYNTHESIS
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_tready)
    else $error("request accepted during pixel memory clear");

  a_no_stage_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !s1_v_r)
    else $error("request in flight during pixel memory clear");

  a_stage_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_go) |=> (s1_v_r && $stable(s1_row_r) && $stable(s1_midx_r)))
    else $error("stalled request lost or changed");

  a_fwd_needs_stage: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fwd_r |-> s1_v_r)
    else $error("forward flag set with no request in flight");

  a_blocked_reads_ff: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_acc_r) |-> (out_rdata_r == ptv_pkg::BYTE_BLOCKED))
    else $error("blocked response without 0xFF data");
`endif

endmodule

### sim/tb_top.sv
// Testbench for planar_tile_vram_port: directed and random requests checked by a predictor.
`timescale 1ns / 100ps

module tb_top;
  import ptv_pkg::*;

  localparam int unsigned PIX_PER_BANK    = ROWS_PER_BANK * 8;
  localparam int unsigned ADDR_TOP        = (1 << ADDR_W) - 1;
  localparam logic        ACT_READ        = 1'b0;
  localparam int          WATCHDOG_CYCLES = 20000;
  localparam int          RX_HOLD_CYCLES  = 300;
  localparam int          RANDOM_ITEMS    = 700;

  typedef struct packed {
    logic [1:0]        mode;
    logic [7:0]        wdata;
    logic              bank;
    logic [ADDR_W-1:0] addr;
    logic              action;
  } vram_req_t;

  typedef struct packed {
    logic       accepted;
    logic [7:0] read_data;
  } vram_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;

  // predictor state
  logic [1:0]   pixel_mem [BANKS][PIX_PER_BANK];
  logic [7:0]   map_mem [BANKS][MAP_AREA_BYTES];
  bit           map_written [BANKS][MAP_AREA_BYTES];
  int           written_map_q[$];
  vram_result_t pending_results[$];
  logic [ADDR_W-1:0] recent_addr_q[$];

  vram_result_t resp_want;
  int           err_count = 0;
  int           idle_cycles = 0;
  int           rx_hold_left = 0;
  int           rx_gap = 0;
  bit           rx_steady = 1'b0;
  bit           tx_steady = 1'b1;

  planar_tile_vram_port dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic vram_result_t predict_vram_access(input vram_req_t r);
    vram_result_t res;
    int b;
    int a;
    int off;
    int base;
    logic hi;
    b = int'(int'(r.bank) % BANKS);
    a = int'(r.addr);
    res.read_data = '0;
    res.accepted = 1'b1;
    if (r.mode == MODE_BLOCK) begin
      res.read_data = BYTE_BLOCKED;
      res.accepted = 1'b0;
    end else if (a >= int'(TILE_AREA_BYTES)) begin
      off = a - int'(TILE_AREA_BYTES);
      if (off < int'(MAP_AREA_BYTES)) begin
        if (r.action == ACT_WRITE) begin
          map_mem[b][off] = r.wdata;
          if (!map_written[b][off]) begin
            map_written[b][off] = 1'b1;
            written_map_q.insert(written_map_q.size(), int'(b * MAP_AREA_BYTES + off));
          end
        end else begin
          res.read_data = map_mem[b][off];
        end
      end
    end else begin
      base = (a >> 1) * 8;
      hi = ~r.addr[0];
      for (int i = 0; i < 8; i++) begin
        if (r.action == ACT_WRITE) begin
          if (hi) pixel_mem[b][base+i][1] = r.wdata[7-i];
          else    pixel_mem[b][base+i][0] = r.wdata[7-i];
        end else begin
          res.read_data[7-i] = hi ? pixel_mem[b][base+i][1] : pixel_mem[b][base+i][0];
        end
      end
    end
    return res;
  endfunction

  function automatic vram_req_t mk_req(input logic act, input int addr, input logic bank,
                                       input logic [7:0] wd, input logic [1:0] mode);
    vram_req_t r;
    r.action = act;
    r.addr   = addr[ADDR_W-1:0];
    r.bank   = bank;
    r.wdata  = wd;
    r.mode   = mode;
    return r;
  endfunction

  function automatic vram_req_t random_request();
    vram_req_t r;
    int pick;
    int idx;
    int off;
    r.action = 1'($urandom_range(0, 1));
    r.bank   = 1'($urandom_range(0, 1));
    r.wdata  = 8'($urandom);
    r.mode   = ($urandom_range(0, 9) == 0) ? MODE_BLOCK : 2'($urandom_range(0, 2));
    pick = $urandom_range(0, 99);
    if (pick < 35 && recent_addr_q.size() > 0)
      r.addr = recent_addr_q[$urandom_range(0, recent_addr_q.size() - 1)]
               ^ ADDR_W'($urandom_range(0, 1));
    else if (pick < 65)
      r.addr = ADDR_W'($urandom_range(0, TILE_AREA_BYTES - 1));
    else if (pick < 75)
      r.addr = ($urandom_range(0, 1)) ? ADDR_W'($urandom_range(0, 31))
               : ADDR_W'($urandom_range(TILE_AREA_BYTES - 32, TILE_AREA_BYTES - 1));
    else
      r.addr = ADDR_W'($urandom_range(TILE_AREA_BYTES, ADDR_TOP));
    // map reads must only touch entries already written
    if (int'(r.addr) >= int'(TILE_AREA_BYTES) && r.action == ACT_READ
        && r.mode != MODE_BLOCK) begin
      off = int'(r.addr) - int'(TILE_AREA_BYTES);
      if (off < int'(MAP_AREA_BYTES) && !map_written[r.bank][off]) begin
        if (written_map_q.size() > 0 && $urandom_range(0, 3) != 0) begin
          idx = written_map_q[$urandom_range(0, written_map_q.size() - 1)];
          r.bank = 1'(idx / MAP_AREA_BYTES);
          r.addr = ADDR_W'(TILE_AREA_BYTES + idx % MAP_AREA_BYTES);
        end else begin
          r.action = ACT_WRITE;
        end
      end
    end
    recent_addr_q.insert(recent_addr_q.size(), r.addr);
    if (recent_addr_q.size() > 8) void'(recent_addr_q.pop_front());
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after the request is taken
  task automatic send_request(input vram_req_t r);
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, r};
    do @(posedge clk); while (!in_tready);
    pending_results.insert(pending_results.size(), predict_vram_access(r));
    @(negedge clk);
  endtask

  task automatic sender_gap();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (!tx_steady && pick >= 70) begin
      n = (pick < 96) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      in_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic test_tile_planes();
    send_request(mk_req(ACT_READ, 0, 1'b0, 8'h00, 2'd0));
    send_request(mk_req(ACT_WRITE, 0, 1'b0, 8'hA5, 2'd0));
    send_request(mk_req(ACT_WRITE, 1, 1'b0, 8'h3C, 2'd1));
    send_request(mk_req(ACT_READ, 0, 1'b0, 8'h00, 2'd2));
    send_request(mk_req(ACT_READ, 1, 1'b0, 8'hFF, 2'd0));
    send_request(mk_req(ACT_WRITE, TILE_AREA_BYTES - 1, 1'b1, 8'hFF, 2'd0));
    send_request(mk_req(ACT_WRITE, TILE_AREA_BYTES - 2, 1'b1, 8'h00, 2'd0));
    send_request(mk_req(ACT_READ, TILE_AREA_BYTES - 1, 1'b1, 8'h00, 2'd0));
    send_request(mk_req(ACT_READ, TILE_AREA_BYTES - 2, 1'b1, 8'h00, 2'd0));
    send_request(mk_req(ACT_READ, 1, 1'b1, 8'h00, 2'd0));
  endtask

  task automatic test_tile_map();
    send_request(mk_req(ACT_WRITE, TILE_AREA_BYTES, 1'b0, 8'h5A, 2'd0));
    send_request(mk_req(ACT_WRITE, ADDR_TOP, 1'b1, 8'hC3, 2'd2));
    send_request(mk_req(ACT_READ, TILE_AREA_BYTES, 1'b0, 8'h00, 2'd1));
    send_request(mk_req(ACT_READ, ADDR_TOP, 1'b1, 8'h00, 2'd0));
  endtask

  task automatic test_blocked();
    send_request(mk_req(ACT_WRITE, 0, 1'b0, 8'hFF, MODE_BLOCK));
    send_request(mk_req(ACT_READ, TILE_AREA_BYTES + 1, 1'b0, 8'h00, MODE_BLOCK));
    send_request(mk_req(ACT_READ, 0, 1'b0, 8'h00, 2'd2));
    send_request(mk_req(ACT_WRITE, ADDR_TOP, 1'b1, 8'h00, MODE_BLOCK));
    send_request(mk_req(ACT_READ, ADDR_TOP, 1'b1, 8'h00, 2'd0));
    send_request(mk_req(ACT_READ, 1, 1'b0, 8'h00, MODE_BLOCK));
  endtask

  task automatic test_input_backpressure();
    rx_hold_left <= RX_HOLD_CYCLES;
    repeat (40) send_request(random_request());
    wait_all_results();
  endtask

  task automatic test_drain_pause();
    repeat (12) send_request(random_request());
    wait_all_results();
    repeat (12) send_request(random_request());
  endtask

  task automatic test_random_traffic();
    rx_steady <= 1'b1;
    tx_steady <= 1'b1;
    repeat (100) send_request(random_request());
    rx_steady <= 1'b0;
    tx_steady <= 1'b0;
    repeat (RANDOM_ITEMS - 100) begin
      send_request(random_request());
      sender_gap();
    end
  endtask

  // receiver: random stalls, steady stretches, and one long hold-off
  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      out_tready <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_steady) begin
      out_tready <= 1'b1;
    end else if (rx_gap > 0) begin
      out_tready <= 1'b0;
      rx_gap <= rx_gap - 1;
    end else if ($urandom_range(0, 99) < 75) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= 1'b0;
      rx_gap <= ($urandom_range(0, 99) < 94) ? $urandom_range(0, 2) : $urandom_range(10, 40);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("response with nothing pending: read_data=%h accepted=%b",
               out_tdata[7:0], out_tdata[8]);
        err_count++;
      end else begin
        resp_want = pending_results.pop_front();
        if (out_tdata[7:0] !== resp_want.read_data) begin
          $error("read_data: expected %h, got %h", resp_want.read_data, out_tdata[7:0]);
          err_count++;
        end
        if (out_tdata[8] !== resp_want.accepted) begin
          $error("accepted: expected %b, got %b", resp_want.accepted, out_tdata[8]);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("planar_tile_vram_port verification failed");
      $finish;
    end
  end

  initial begin
    for (int b = 0; b < BANKS; b++) begin
      for (int i = 0; i < PIX_PER_BANK; i++) pixel_mem[b][i] = 2'b00;
      for (int i = 0; i < MAP_AREA_BYTES; i++) begin
        map_mem[b][i] = 8'h00;
        map_written[b][i] = 1'b0;
      end
    end
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    rx_steady <= 1'b1;
    test_tile_planes();
    test_tile_map();
    test_blocked();
    test_input_backpressure();
    rx_steady <= 1'b0;
    tx_steady <= 1'b0;
    test_drain_pause();
    test_random_traffic();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("planar_tile_vram_port verification clean");
    end else begin
      $display("planar_tile_vram_port verification failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/ptv_pkg.sv
rtl/ptv_ram.sv
rtl/planar_tile_vram_port.sv
sim/tb_top.sv
